// File: src/running_line_fit_accumulator_unit_macros.svh
// Assertion macros shared by the line fit accumulator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RUNNING_LINE_FIT_ACCUMULATOR_UNIT_MACROS_SVH
`define RUNNING_LINE_FIT_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RLFA_ASSERT_HOLD(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RLFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rlfa_pkg.sv
// Shared types, codes and helper functions of the line fit accumulator.
// No dependencies; imported by rlfa_wide_unit and the top level.
package rlfa_pkg;

  // wide working width of the shared arithmetic unit
  localparam int unsigned WW     = 128;
  localparam int unsigned MUL_W  = 64;
  localparam int unsigned ROOT_W = 64;
  localparam int unsigned SQ_W   = ROOT_W + 4;
  localparam int unsigned SUM1_W = 33;
  localparam int unsigned SUM2_W = 48;

  // item kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_REM_EMPTY = 2'd1;
  localparam logic [1:0] STAT_ADD_FULL  = 2'd2;
  localparam logic [1:0] STAT_ZERO_VAR  = 2'd3;

  // shared unit operations
  localparam logic [1:0] OP_MAC  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic signed [15:0] CORR_ONE = 16'sd16384;

  // request to the shared unit
  typedef struct packed {
    logic [1:0]    op;
    logic          sub;   // MAC: subtract the product from the addend
    logic          rnd;   // DIV: round to nearest, ties away from zero
    logic [WW-1:0] opa;
    logic [WW-1:0] opb;
    logic [WW-1:0] add;
  } rlfa_req_t;

  // saturate a signed wide value to 32 bits
  function automatic logic [31:0] sat32(logic [WW-1:0] v);
    logic [WW-32:0] hi;
    hi = v[WW-1:31];
    if (hi == '0 || hi == '1) begin
      return v[31:0];
    end else if (v[WW-1]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

  // correlation: saturate, then clamp to plus or minus one in Q1.14
  function automatic logic [15:0] corr_clamp(logic [WW-1:0] v);
    logic signed [31:0] s;
    s = sat32(v);
    if (s > 32'sd16384) begin
      return CORR_ONE;
    end else if (s < -32'sd16384) begin
      return -CORR_ONE;
    end else begin
      return s[15:0];
    end
  endfunction

endpackage

// File: src/running_line_fit_accumulator_unit.sv
// Running least-squares line fit accumulator, top level.
// Depends on rlfa_pkg and rlfa_wide_unit.
//
// Each input beat adds a point, removes one, clears the sums or only queries;
// every beat returns one result beat with the count, the least-squares slope,
// the intercept for the given slope, the rms residual about the given line and
// the correlation coefficient. One item is in work at a time: the input is
// ready only between items. All products, quotients and roots go through one
// shared radix-2 unit, one bit per cycle, and a step whose result is not
// needed does not start the unit. A full item (update, 19 multiply-accumulates,
// 4 divides, 3 roots) starts the unit at every step; a query on an empty
// accumulator starts it at none. A finished result waits in the output
// register while the next beat is taken.
`include "running_line_fit_accumulator_unit_macros.svh"

module running_line_fit_accumulator_unit import rlfa_pkg::*; #(
  parameter  int unsigned COORD_WIDTH = 16,
  parameter  int unsigned COUNT_WIDTH = 16,
  localparam int unsigned IN_TW  = ((2 * COORD_WIDTH + 64 + 7) / 8) * 8,
  localparam int unsigned OUT_TW = 136
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // x, y, given_slope, given_intercept
  input  logic [IN_TW-1:0]  s_axis_tdata_i,
  // kind
  input  logic [1:0]        s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // point_total, fit_slope, fit_intercept, fit_rms, correlation, status
  output logic [OUT_TW-1:0] m_axis_tdata_o
);

  localparam int unsigned CNT_EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  localparam logic [4:0] ST_U_XX  = 5'd0;
  localparam logic [4:0] ST_U_XY  = 5'd1;
  localparam logic [4:0] ST_U_YY  = 5'd2;
  localparam logic [4:0] ST_NUM0  = 5'd3;
  localparam logic [4:0] ST_NUM1  = 5'd4;
  localparam logic [4:0] ST_DX0   = 5'd5;
  localparam logic [4:0] ST_DX1   = 5'd6;
  localparam logic [4:0] ST_DY0   = 5'd7;
  localparam logic [4:0] ST_DY1   = 5'd8;
  localparam logic [4:0] ST_SLOPE = 5'd9;
  localparam logic [4:0] ST_SQX   = 5'd10;
  localparam logic [4:0] ST_SQY   = 5'd11;
  localparam logic [4:0] ST_PXY   = 5'd12;
  localparam logic [4:0] ST_CORR  = 5'd13;
  localparam logic [4:0] ST_ICPT0 = 5'd14;
  localparam logic [4:0] ST_ICPT1 = 5'd15;
  localparam logic [4:0] ST_E0    = 5'd16;
  localparam logic [4:0] ST_E1    = 5'd17;
  localparam logic [4:0] ST_E2    = 5'd18;
  localparam logic [4:0] ST_E3    = 5'd19;
  localparam logic [4:0] ST_E4    = 5'd20;
  localparam logic [4:0] ST_E5    = 5'd21;
  localparam logic [4:0] ST_E6    = 5'd22;
  localparam logic [4:0] ST_E7    = 5'd23;
  localparam logic [4:0] ST_EDIV  = 5'd24;
  localparam logic [4:0] ST_RMS   = 5'd25;

  // control and running sums
  logic [1:0]                state_q;
  logic [4:0]                step_q;
  logic                      m_tvalid_q;
  logic                      upd_q, rm_q;
  logic [COUNT_WIDTH-1:0]    cnt_q;
  logic signed [SUM1_W-1:0]  sx_q, sy_q;
  logic signed [SUM2_W-1:0]  sxx_q, sxy_q, syy_q;

  // latched beat, intermediates and results
  logic signed [COORD_WIDTH-1:0] x_q, y_q;
  logic signed [31:0]            gm_q, gc_q;
  logic signed [WW-1:0]          num_q, dx_q, dy_q, tmp_q, e_q;
  logic [31:0]                   slope_q, icpt_q, rms_q;
  logic [15:0]                   corr_q;
  logic [1:0]                    status_q;
  logic [OUT_TW-1:0]             m_tdata_q;

  // input beat fields
  logic                          s_hs;
  logic [1:0]                    in_kind;
  logic signed [COORD_WIDTH-1:0] in_x, in_y;
  assign s_axis_tready_o = state_q == S_IDLE;
  assign s_hs    = s_axis_tvalid_i && s_axis_tready_o;
  assign in_kind = s_axis_tuser_i;
  assign in_x    = s_axis_tdata_i[COORD_WIDTH-1:0];
  assign in_y    = s_axis_tdata_i[2*COORD_WIDTH-1:COORD_WIDTH];

  // accept decisions
  logic       cnt_full, cnt_empty, in_upd;
  logic [1:0] in_status;
  assign cnt_full  = &cnt_q;
  assign cnt_empty = cnt_q == '0;
  always_comb begin
    in_upd    = 1'b0;
    in_status = STAT_OK;
    case (in_kind)
      KIND_ADD: begin
        if (cnt_full) in_status = STAT_ADD_FULL;
        else in_upd = 1'b1;
      end
      KIND_REMOVE: begin
        if (cnt_empty) in_status = STAT_REM_EMPTY;
        else in_upd = 1'b1;
      end
      default: ;
    endcase
  end

  // fit conditions on the current sums
  logic n_ge1, n_ge2, dx_zero, corr_ok;
  assign n_ge1   = !cnt_empty;
  assign n_ge2   = cnt_q > COUNT_WIDTH'(1);
  assign dx_zero = dx_q == '0;
  assign corr_ok = n_ge2 && !dx_zero && (dy_q != '0) && (dx_q[WW-1] == dy_q[WW-1]);

  logic step_need;
  always_comb begin
    case (step_q)
      ST_U_XX, ST_U_XY, ST_U_YY:                          step_need = upd_q;
      ST_NUM0, ST_NUM1, ST_DX0, ST_DX1, ST_DY0, ST_DY1:   step_need = n_ge2;
      ST_SLOPE:                                           step_need = n_ge2 && !dx_zero;
      ST_SQX, ST_SQY, ST_PXY, ST_CORR:                    step_need = corr_ok;
      ST_ICPT0, ST_ICPT1, ST_E0, ST_E1, ST_E2, ST_E3,
      ST_E4, ST_E5, ST_E6, ST_E7:                         step_need = n_ge1;
      ST_EDIV, ST_RMS:                                    step_need = n_ge1 && !e_q[WW-1];
      default:                                            step_need = 1'b0;
    endcase
  end

  // operand views
  logic [WW-1:0] n_w, x_w, y_w, sx_w, sy_w, sxx_w, sxy_w, syy_w, gm_w, gc_w;
  logic [WW-1:0] mag_dx, mag_dy;
  assign n_w    = WW'(cnt_q);
  assign x_w    = WW'(x_q);
  assign y_w    = WW'(y_q);
  assign sx_w   = WW'(sx_q);
  assign sy_w   = WW'(sy_q);
  assign sxx_w  = WW'(sxx_q);
  assign sxy_w  = WW'(sxy_q);
  assign syy_w  = WW'(syy_q);
  assign gm_w   = WW'(gm_q);
  assign gc_w   = WW'(gc_q);
  assign mag_dx = dx_q[WW-1] ? WW'(-dx_q) : WW'(dx_q);
  assign mag_dy = dy_q[WW-1] ? WW'(-dy_q) : WW'(dy_q);

  // request per step
  rlfa_req_t req;
  always_comb begin
    req    = '0;
    req.op = OP_MAC;
    case (step_q)
      ST_U_XX: begin req.opa = x_w; req.opb = x_w; req.add = sxx_w; req.sub = rm_q; end
      ST_U_XY: begin req.opa = x_w; req.opb = y_w; req.add = sxy_w; req.sub = rm_q; end
      ST_U_YY: begin req.opa = y_w; req.opb = y_w; req.add = syy_w; req.sub = rm_q; end
      ST_NUM0: begin req.opa = n_w; req.opb = sxy_w; end
      ST_NUM1: begin req.opa = sx_w; req.opb = sy_w; req.add = num_q; req.sub = 1'b1; end
      ST_DX0:  begin req.opa = n_w; req.opb = sxx_w; end
      ST_DX1:  begin req.opa = sx_w; req.opb = sx_w; req.add = dx_q; req.sub = 1'b1; end
      ST_DY0:  begin req.opa = n_w; req.opb = syy_w; end
      ST_DY1:  begin req.opa = sy_w; req.opb = sy_w; req.add = dy_q; req.sub = 1'b1; end
      ST_SLOPE: begin
        req.op = OP_DIV; req.rnd = 1'b1; req.opa = num_q <<< 16; req.opb = dx_q;
      end
      ST_SQX:  begin req.op = OP_SQRT; req.opa = mag_dx << 32; end
      ST_SQY:  begin req.op = OP_SQRT; req.opa = mag_dy << 32; end
      ST_PXY:  begin req.opa = tmp_q; req.opb = e_q; end
      ST_CORR: begin
        req.op = OP_DIV; req.rnd = 1'b1; req.opa = num_q <<< 46; req.opb = tmp_q;
      end
      ST_ICPT0: begin req.opa = gm_w; req.opb = sx_w; req.add = sy_w << 16; req.sub = 1'b1; end
      ST_ICPT1: begin req.op = OP_DIV; req.rnd = 1'b1; req.opa = tmp_q; req.opb = n_w; end
      ST_E0:   begin req.opa = gm_w; req.opb = gm_w; end
      ST_E1:   begin req.opa = tmp_q; req.opb = sxx_w; req.add = syy_w << 32; end
      ST_E2:   begin req.opa = gm_w; req.opb = gc_w; end
      ST_E3:   begin req.opa = tmp_q; req.opb = sx_w << 1; req.add = e_q; end
      ST_E4:   begin req.opa = gm_w << 17; req.opb = sxy_w; req.add = e_q; req.sub = 1'b1; end
      ST_E5:   begin req.opa = gc_w; req.opb = gc_w; end
      ST_E6:   begin req.opa = n_w; req.opb = tmp_q; req.add = e_q; end
      ST_E7:   begin req.opa = gc_w << 17; req.opb = sy_w; req.add = e_q; req.sub = 1'b1; end
      ST_EDIV: begin req.op = OP_DIV; req.opa = e_q; req.opb = n_w; end
      ST_RMS:  begin req.op = OP_SQRT; req.opa = tmp_q; end
      default: ;
    endcase
  end

  logic          u_start, u_done;
  logic [WW-1:0] u_res;
  assign u_start = (state_q == S_RUN) && step_need;

  rlfa_wide_unit u_wide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (u_start),
    .req_i   (req),
    .done_o  (u_done),
    .res_o   (u_res)
  );

  logic out_load, step_last;
  assign out_load  = (state_q == S_OUT) && (!m_tvalid_q || m_axis_tready_i);
  assign step_last = step_q == ST_RMS;

  // sequencer, count and sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= ST_U_XX;
      m_tvalid_q <= 1'b0;
      upd_q      <= 1'b0;
      rm_q       <= 1'b0;
      cnt_q      <= '0;
      sx_q       <= '0;
      sy_q       <= '0;
      sxx_q      <= '0;
      sxy_q      <= '0;
      syy_q      <= '0;
    end else begin
      // output valid: set on load, cleared once the beat is taken
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tvalid_q && m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_hs) begin
            state_q <= S_RUN;
            step_q  <= ST_U_XX;
            upd_q   <= in_upd;
            rm_q    <= in_kind == KIND_REMOVE;
            case (in_kind)
              KIND_ADD: begin
                if (!cnt_full) begin
                  cnt_q <= cnt_q + COUNT_WIDTH'(1);
                  sx_q  <= sx_q + SUM1_W'(in_x);
                  sy_q  <= sy_q + SUM1_W'(in_y);
                end
              end
              KIND_REMOVE: begin
                if (!cnt_empty) begin
                  cnt_q <= cnt_q - COUNT_WIDTH'(1);
                  sx_q  <= sx_q - SUM1_W'(in_x);
                  sy_q  <= sy_q - SUM1_W'(in_y);
                end
              end
              KIND_CLEAR: begin
                cnt_q <= '0;
                sx_q  <= '0;
                sy_q  <= '0;
                sxx_q <= '0;
                sxy_q <= '0;
                syy_q <= '0;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          if (step_need) state_q <= S_WAIT;
          else if (step_last) state_q <= S_OUT;
          else step_q <= step_q + 5'd1;
        end
        S_WAIT: begin
          if (u_done) begin
            case (step_q)
              ST_U_XX: sxx_q <= u_res[SUM2_W-1:0];
              ST_U_XY: sxy_q <= u_res[SUM2_W-1:0];
              ST_U_YY: syy_q <= u_res[SUM2_W-1:0];
              default: ;
            endcase
            if (step_last) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_RUN;
              step_q  <= step_q + 5'd1;
            end
          end
        end
        S_OUT: begin
          if (out_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // beat latch, intermediates and result fields
  logic [CNT_EXT_W-1:0] cnt_ext;
  assign cnt_ext = CNT_EXT_W'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (s_hs) begin
      x_q      <= in_x;
      y_q      <= in_y;
      gm_q     <= s_axis_tdata_i[2*COORD_WIDTH+31:2*COORD_WIDTH];
      gc_q     <= s_axis_tdata_i[2*COORD_WIDTH+63:2*COORD_WIDTH+32];
      status_q <= in_status;
      slope_q  <= '0;
      icpt_q   <= '0;
      rms_q    <= '0;
      corr_q   <= CORR_ONE;
    end
    // vertical x spread: slope saturates by sign of the cross term
    if (state_q == S_RUN && !step_need && step_q == ST_SLOPE && n_ge2) begin
      slope_q <= num_q[WW-1] ? 32'h8000_0000 : ((num_q == '0) ? 32'h0 : 32'h7fff_ffff);
      if (status_q == STAT_OK) status_q <= STAT_ZERO_VAR;
    end
    if (state_q == S_WAIT && u_done) begin
      case (step_q)
        ST_NUM0, ST_NUM1: num_q <= u_res;
        ST_DX0, ST_DX1:   dx_q  <= u_res;
        ST_DY0, ST_DY1:   dy_q  <= u_res;
        ST_SLOPE:         slope_q <= sat32(u_res);
        ST_SQX, ST_PXY, ST_ICPT0, ST_E0, ST_E2, ST_E5, ST_EDIV: tmp_q <= u_res;
        ST_SQY, ST_E1, ST_E3, ST_E4, ST_E6, ST_E7:              e_q   <= u_res;
        ST_CORR:          corr_q <= corr_clamp(u_res);
        ST_ICPT1:         icpt_q <= sat32(u_res);
        ST_RMS:           rms_q  <= (|u_res[WW-1:32]) ? 32'hffff_ffff : u_res[31:0];
        default: ;
      endcase
    end
    if (out_load) begin
      m_tdata_q <= {6'b0, status_q, corr_q, rms_q, icpt_q, slope_q, cnt_ext[15:0]};
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

  `RLFA_ASSERT_HOLD(a_done_in_wait, clk_i, rst_ni, u_done, state_q == S_WAIT, "stray unit result")
  `RLFA_ASSERT_NEXT(a_out_blocked, clk_i, rst_ni, state_q == S_OUT && m_tvalid_q && !m_axis_tready_i, state_q == S_OUT, "result overwrote a pending beat")
  `RLFA_ASSERT_NEXT(a_rm_count, clk_i, rst_ni, s_hs && in_kind == KIND_REMOVE && !cnt_empty, cnt_q == COUNT_WIDTH'($past(cnt_q) - 1'b1), "remove did not drop the count")

endmodule

// File: src/rlfa_wide_unit.sv
// Shared iterative arithmetic unit: multiply-accumulate, divide and square root.
// One radix-2 step per cycle on 128-bit words; depends on rlfa_pkg.
`include "running_line_fit_accumulator_unit_macros.svh"

module rlfa_wide_unit import rlfa_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rlfa_req_t     req_i,
  output logic          done_o,
  output logic [WW-1:0] res_o
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_PREP = 3'd1;
  localparam logic [2:0] U_MUL  = 3'd2;
  localparam logic [2:0] U_DIV  = 3'd3;
  localparam logic [2:0] U_SQRT = 3'd4;
  localparam logic [2:0] U_FIN  = 3'd5;

  logic [2:0]        ust_q;
  logic [6:0]        cnt_q;
  logic              done_q;
  logic              neg_q, rnd_q;
  logic [WW-1:0]     ra_q, rb_q, rr_q, res_q;
  logic [ROOT_W-1:0] rq_q;

  // operand magnitudes at start
  logic [MUL_W-1:0] a_mul, b_mul, a_mul_mag, b_mul_mag;
  logic [WW-1:0]    a_mag, b_mag;
  assign a_mul     = req_i.opa[MUL_W-1:0];
  assign b_mul     = req_i.opb[MUL_W-1:0];
  assign a_mul_mag = a_mul[MUL_W-1] ? -a_mul : a_mul;
  assign b_mul_mag = b_mul[MUL_W-1] ? -b_mul : b_mul;
  assign a_mag     = req_i.opa[WW-1] ? -req_i.opa : req_i.opa;
  assign b_mag     = req_i.opb[WW-1] ? -req_i.opb : req_i.opb;

  // multiply step: add or subtract shifted multiplicand
  logic [WW-1:0] mac_nx;
  assign mac_nx = neg_q ? rr_q - ra_q : rr_q + ra_q;

  // restoring divide step
  logic [WW-1:0] div_sh, div_df;
  logic          div_ge;
  assign div_sh = {rr_q[WW-2:0], ra_q[WW-1]};
  assign div_ge = div_sh >= rb_q;
  assign div_df = div_sh - rb_q;

  // digit-by-digit square root step
  logic [SQ_W-1:0]   sq_sh, sq_tr, sq_df;
  logic              sq_ge;
  logic [ROOT_W-1:0] root_nx;
  assign sq_sh   = {rr_q[SQ_W-3:0], ra_q[WW-1:WW-2]};
  assign sq_tr   = {2'b00, rq_q, 2'b01};
  assign sq_ge   = sq_sh >= sq_tr;
  assign sq_df   = sq_sh - sq_tr;
  assign root_nx = {rq_q[ROOT_W-2:0], sq_ge};

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ust_q  <= U_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (ust_q)
        U_IDLE: begin
          if (start_i) begin
            cnt_q <= 7'(MUL_W - 1);
            case (req_i.op)
              OP_MAC:  ust_q <= U_MUL;
              OP_DIV:  ust_q <= U_PREP;
              OP_SQRT: ust_q <= U_SQRT;
              default: ust_q <= U_IDLE;
            endcase
          end
        end
        U_PREP: begin
          cnt_q <= 7'(WW - 1);
          ust_q <= U_DIV;
        end
        U_MUL, U_SQRT: begin
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == '0) begin
            done_q <= 1'b1;
            ust_q  <= U_IDLE;
          end
        end
        U_DIV: begin
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == '0) ust_q <= U_FIN;
        end
        U_FIN: begin
          done_q <= 1'b1;
          ust_q  <= U_IDLE;
        end
        default: ust_q <= U_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (ust_q)
      U_IDLE: begin
        if (start_i) begin
          rnd_q <= req_i.rnd;
          case (req_i.op)
            OP_MAC: begin
              ra_q  <= WW'(a_mul_mag);
              rb_q  <= WW'(b_mul_mag);
              rr_q  <= req_i.add;
              neg_q <= a_mul[MUL_W-1] ^ b_mul[MUL_W-1] ^ req_i.sub;
            end
            OP_DIV: begin
              ra_q  <= a_mag;
              rb_q  <= b_mag;
              rr_q  <= '0;
              neg_q <= req_i.opa[WW-1] ^ req_i.opb[WW-1];
            end
            OP_SQRT: begin
              ra_q <= req_i.opa;
              rr_q <= '0;
              rq_q <= '0;
            end
            default: ;
          endcase
        end
      end
      U_PREP: begin
        // rounding: (2|a| + |d|) / (2|d|)
        if (rnd_q) begin
          ra_q <= {ra_q[WW-2:0], 1'b0} + rb_q;
          rb_q <= {rb_q[WW-2:0], 1'b0};
        end
      end
      U_MUL: begin
        if (rb_q[0]) rr_q <= mac_nx;
        ra_q <= {ra_q[WW-2:0], 1'b0};
        rb_q <= {1'b0, rb_q[WW-1:1]};
        if (cnt_q == '0) res_q <= rb_q[0] ? mac_nx : rr_q;
      end
      U_DIV: begin
        rr_q <= div_ge ? div_df : div_sh;
        ra_q <= {ra_q[WW-2:0], div_ge};
      end
      U_SQRT: begin
        rr_q <= WW'(sq_ge ? sq_df : sq_sh);
        rq_q <= root_nx;
        ra_q <= {ra_q[WW-3:0], 2'b00};
        if (cnt_q == '0) res_q <= WW'(root_nx);
      end
      U_FIN: res_q <= neg_q ? -ra_q : ra_q;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `RLFA_ASSERT_HOLD(a_start_idle, clk_i, rst_ni, start_i, ust_q == U_IDLE, "start while busy")
  `RLFA_ASSERT_HOLD(a_done_idle, clk_i, rst_ni, done_q, ust_q == U_IDLE, "done while busy")
  `RLFA_ASSERT_HOLD(a_div_rem, clk_i, rst_ni, ust_q == U_DIV, rr_q < rb_q, "remainder overrun")

endmodule

// File: tb/sv/running_line_fit_accumulator_unit_test.sv
// Self-checking testbench for running_line_fit_accumulator_unit.
// Depends on rlfa_pkg and the RTL; predicts every result beat with an
// exact integer model of the least-squares sums and compares field by field.
`timescale 1ns / 1ps

module running_line_fit_accumulator_unit_test;
  import rlfa_pkg::*;

  localparam int unsigned IN_TW  = 96;
  localparam int unsigned OUT_TW = 136;
  localparam logic [15:0] COUNT_FULL = 16'hffff;
  localparam int RANDOM_ITEMS = 1100;

  typedef logic signed [127:0] big_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [31:0] gm;
    logic signed [31:0] gc;
  } point_op_t;

  typedef struct {
    logic [15:0] total;
    logic [31:0] slope;
    logic [31:0] icpt;
    logic [31:0] rms;
    logic [15:0] corr;
    logic [1:0]  status;
  } fit_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [IN_TW-1:0]  s_axis_tdata_i;
  logic [1:0]        s_axis_tuser_i;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [OUT_TW-1:0] m_axis_tdata_o;

  // predictor state
  logic [15:0]        acc_count;
  logic signed [32:0] acc_sx, acc_sy;
  logic signed [47:0] acc_sxx, acc_sxy, acc_syy;

  fit_t pending_fits[$];
  int   fail_count;
  bit   stall_enable;

  // points added and not yet removed, for well-formed removes
  point_op_t live_points[$];

  running_line_fit_accumulator_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!stall_enable || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // rounded division, ties away from zero
  function automatic big_t div_round(big_t a, big_t d);
    logic [127:0] ma, md, q;
    ma = a[127] ? -a : a;
    md = d[127] ? -d : d;
    q = ((ma << 1) + md) / (md << 1);
    return (a[127] != d[127]) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] clip32(big_t v);
    if (v > 128'sd2147483647) return 32'h7fff_ffff;
    if (v < -128'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // apply one item to the sums and work out the fit it reports
  function automatic fit_t fit_after(point_op_t op);
    fit_t f;
    big_t nn, sx, sy, sxx, sxy, syy, gm, gc, num, dx, dy, den, c, e;
    logic [63:0] rx, ry, rr;
    f.status = STAT_OK;
    case (op.kind)
      KIND_ADD: begin
        if (acc_count == COUNT_FULL) begin
          f.status = STAT_ADD_FULL;
        end else begin
          acc_count = acc_count + 16'd1;
          acc_sx  = acc_sx + op.x;
          acc_sy  = acc_sy + op.y;
          acc_sxx = acc_sxx + 48'(op.x) * 48'(op.x);
          acc_sxy = acc_sxy + 48'(op.x) * 48'(op.y);
          acc_syy = acc_syy + 48'(op.y) * 48'(op.y);
        end
      end
      KIND_REMOVE: begin
        if (acc_count == 0) begin
          f.status = STAT_REM_EMPTY;
        end else begin
          acc_count = acc_count - 16'd1;
          acc_sx  = acc_sx - op.x;
          acc_sy  = acc_sy - op.y;
          acc_sxx = acc_sxx - 48'(op.x) * 48'(op.x);
          acc_sxy = acc_sxy - 48'(op.x) * 48'(op.y);
          acc_syy = acc_syy - 48'(op.y) * 48'(op.y);
        end
      end
      KIND_CLEAR: begin
        acc_count = '0;
        acc_sx = '0; acc_sy = '0;
        acc_sxx = '0; acc_sxy = '0; acc_syy = '0;
      end
      default: ;
    endcase

    nn = $signed({112'd0, acc_count});
    sx = acc_sx; sy = acc_sy;
    sxx = acc_sxx; sxy = acc_sxy; syy = acc_syy;
    gm = op.gm; gc = op.gc;
    num = nn * sxy - sx * sy;
    dx  = nn * sxx - sx * sx;
    dy  = nn * syy - sy * sy;

    f.total = acc_count;
    f.slope = '0;
    f.icpt  = '0;
    f.rms   = '0;
    f.corr  = CORR_ONE;

    if (acc_count >= 2) begin
      if (dx == 0) begin
        if (f.status == STAT_OK) f.status = STAT_ZERO_VAR;
        f.slope = num[127] ? 32'h8000_0000 : (num == 0 ? 32'h0 : 32'h7fff_ffff);
      end else begin
        f.slope = clip32(div_round(num <<< 16, dx));
      end
      if (dx != 0 && dy != 0 && dx[127] == dy[127]) begin
        rx = isqrt((dx[127] ? -dx : dx) << 32);
        ry = isqrt((dy[127] ? -dy : dy) << 32);
        den = $signed({64'd0, rx} * {64'd0, ry});
        c = $signed(clip32(div_round(num <<< 46, den)));
        if (c > 128'sd16384) c = 128'sd16384;
        if (c < -128'sd16384) c = -128'sd16384;
        f.corr = c[15:0];
      end
    end

    if (acc_count >= 1) begin
      f.icpt = clip32(div_round((sy <<< 16) - gm * sx, nn));
      e = (syy <<< 32) + gm * gm * sxx + ((gm * gc * sx) <<< 1)
          - ((gm * sxy) <<< 17) + nn * gc * gc - ((gc * sy) <<< 17);
      if (!e[127]) begin
        rr = isqrt($unsigned(e) / $unsigned(nn));
        f.rms = (rr > 64'hffff_ffff) ? 32'hffff_ffff : rr[31:0];
      end
    end
    return f;
  endfunction

  // send one beat; entered and left at a falling edge
  task automatic send_op(logic [1:0] kind, logic signed [15:0] x, logic signed [15:0] y,
                         logic signed [31:0] gm, logic signed [31:0] gc);
    point_op_t op;
    int gap;
    op.kind = kind; op.x = x; op.y = y; op.gm = gm; op.gc = gc;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {gc, gm, y, x};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_fits.push_back(fit_after(op));
    if (kind == KIND_ADD && acc_count != 0) live_points.push_back(op);
    if (kind == KIND_CLEAR) live_points.delete();
    @(negedge clk_i);
  endtask

  task automatic test_extremes();
    send_op(KIND_QUERY, 16'sh7fff, -16'sh8000, 32'sh7fff_ffff, -32'sh8000_0000);
    send_op(KIND_REMOVE, 16'sd3, 16'sd4, 32'sd0, 32'sd0);
    send_op(KIND_ADD, -16'sh8000, -16'sh8000, -32'sh8000_0000, 32'sh7fff_ffff);
    send_op(KIND_ADD, 16'sh7fff, 16'sh7fff, 32'sh7fff_ffff, -32'sh8000_0000);
    send_op(KIND_ADD, 16'sh7fff, -16'sh8000, -32'sd1, -32'sd1);
    send_op(KIND_QUERY, 16'sd0, 16'sd0, 32'sh0001_0000, 32'sd0);
    send_op(KIND_REMOVE, 16'sh7fff, -16'sh8000, 32'sh0000_ffff, 32'shffff_0000);
    send_op(KIND_QUERY, -16'sd1, -16'sd1, 32'sh5555_5555, 32'shaaaa_aaaa);
    send_op(KIND_CLEAR, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
  endtask

  task automatic test_special_cases();
    // zero x variance: vertical points
    send_op(KIND_ADD, 16'sd5, 16'sd1, 32'sd0, 32'sd0);
    send_op(KIND_ADD, 16'sd5, 16'sd9, 32'sd0, 32'sd0);
    // add with zero y variance: correlation falls back to one
    send_op(KIND_CLEAR, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    send_op(KIND_ADD, 16'sd1, 16'sd7, 32'sd0, 32'sh0007_0000);
    send_op(KIND_ADD, 16'sd4, 16'sd7, 32'sd0, 32'sh0007_0000);
    send_op(KIND_ADD, -16'sd9, 16'sd7, 32'sd0, 32'sh0007_0000);
    // a perfect line with negative slope
    send_op(KIND_CLEAR, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    send_op(KIND_ADD, 16'sd0, 16'sd10, -32'sh0002_0000, 32'sh000a_0000);
    send_op(KIND_ADD, 16'sd1, 16'sd8, -32'sh0002_0000, 32'sh000a_0000);
    send_op(KIND_ADD, 16'sd2, 16'sd6, -32'sh0002_0000, 32'sh000a_0000);
    // removing a point never added drives the residual sum negative
    send_op(KIND_CLEAR, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    send_op(KIND_ADD, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    send_op(KIND_ADD, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    send_op(KIND_REMOVE, 16'sd30000, 16'sd30000, 32'sd0, 32'sd0);
    send_op(KIND_CLEAR, 16'sd0, 16'sd0, 32'sd0, 32'sd0);
    live_points.delete();
  endtask

  task automatic test_random_stream();
    int r, idx;
    logic signed [15:0] x, y;
    logic signed [31:0] gm, gc;
    point_op_t p;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // switch between stretches with and without idling
      if (i % 150 == 0) stall_enable = ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
        x = 16'($urandom); y = 16'($urandom);
      end else begin
        x = $signed(16'($urandom_range(0, 200))) - 16'sd100;
        y = $signed(16'($urandom_range(0, 2000))) - 16'sd1000;
      end
      if ($urandom_range(0, 2) == 0) begin
        gm = $urandom; gc = $urandom;
      end else begin
        gm = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
        gc = $signed(32'($urandom_range(0, 32'h0800_0000))) - 32'sh0400_0000;
      end
      if (r < 60) begin
        send_op(KIND_ADD, x, y, gm, gc);
      end else if (r < 75) begin
        send_op(KIND_QUERY, x, y, gm, gc);
      end else if (r < 92) begin
        // mostly undo a real point, sometimes a stray one
        if (live_points.size() > 0 && $urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, live_points.size() - 1);
          p = live_points[idx];
          live_points.delete(idx);
          send_op(KIND_REMOVE, p.x, p.y, gm, gc);
        end else begin
          send_op(KIND_REMOVE, x, y, gm, gc);
        end
      end else begin
        send_op(KIND_CLEAR, x, y, gm, gc);
      end
    end
  endtask

  // result side back-pressure
  initial begin
    int gap;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    fit_t exp_fit;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_fits.size() == 0) begin
        $error("result beat with no prediction waiting");
        fail_count++;
      end else begin
        exp_fit = pending_fits.pop_front();
        if (m_axis_tdata_o[15:0] !== exp_fit.total) begin
          $error("point_total: expected %0d, got %0d", exp_fit.total, m_axis_tdata_o[15:0]);
          fail_count++;
        end
        if (m_axis_tdata_o[47:16] !== exp_fit.slope) begin
          $error("fit_slope: expected %0d, got %0d", $signed(exp_fit.slope),
                 $signed(m_axis_tdata_o[47:16]));
          fail_count++;
        end
        if (m_axis_tdata_o[79:48] !== exp_fit.icpt) begin
          $error("fit_intercept: expected %0d, got %0d", $signed(exp_fit.icpt),
                 $signed(m_axis_tdata_o[79:48]));
          fail_count++;
        end
        if (m_axis_tdata_o[111:80] !== exp_fit.rms) begin
          $error("fit_rms: expected %0d, got %0d", exp_fit.rms, m_axis_tdata_o[111:80]);
          fail_count++;
        end
        if (m_axis_tdata_o[127:112] !== exp_fit.corr) begin
          $error("correlation: expected %0d, got %0d", $signed(exp_fit.corr),
                 $signed(m_axis_tdata_o[127:112]));
          fail_count++;
        end
        if (m_axis_tdata_o[129:128] !== exp_fit.status) begin
          $error("status: expected %0d, got %0d", exp_fit.status, m_axis_tdata_o[129:128]);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    fail_count      = 0;
    stall_enable    = 1'b1;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = KIND_QUERY;
    acc_count = '0;
    acc_sx = '0; acc_sy = '0;
    acc_sxx = '0; acc_sxy = '0; acc_syy = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_extremes();
    test_special_cases();
    test_random_stream();
    s_axis_tvalid_i <= 1'b0;

    while (pending_fits.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/rlfa_pkg.sv
src/rlfa_wide_unit.sv
src/running_line_fit_accumulator_unit.sv
tb/sv/running_line_fit_accumulator_unit_test.sv
